@@ src/pce_pkg.sv @@
// Shared types, constants and command/status structs for the pager codeword encoder.
// Used by pce_bch, pce_dp, pce_ctrl and the top level; depends on nothing else.
package pce_pkg;

    localparam int BATCH_COUNT      = 2;
    localparam int FRAMES_PER_BATCH = 16;
    localparam int TOTAL_FRAMES     = BATCH_COUNT * FRAMES_PER_BATCH;
    localparam int FP_W             = $clog2(TOTAL_FRAMES + 1);
    localparam int FRAME_IDX_W      = $clog2(FRAMES_PER_BATCH);
    localparam int MAX_RESULTS      = 40;
    localparam int RES_W            = $clog2(MAX_RESULTS + 1);

    localparam int PAYLOAD_BITS     = 20;
    localparam int FILL_W           = $clog2(PAYLOAD_BITS + 1);
    localparam int CHAR_BITS        = 7;
    localparam int BITCNT_W         = $clog2(CHAR_BITS + 1);

    localparam int BCH_BITS         = 21;
    localparam int BCH_STEP         = 3;
    localparam int BCH_ITER         = BCH_BITS / BCH_STEP;
    localparam int BCH_CNT_W        = $clog2(BCH_ITER);

    localparam logic [31:0] BCH_GEN   = 32'hED20_0000;
    localparam logic [31:0] DATA_MASK = 32'hFFFF_F800;
    localparam logic [CHAR_BITS-1:0] EOT_CHAR   = 7'h04;
    localparam logic [CHAR_BITS-1:0] CHAR_LIMIT = 7'd80;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_WORD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_BATCH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARS    = 2'd3;

    localparam logic [31:0] SYNC_WORD_RST = 32'h7CD2_15D8;
    localparam logic [31:0] IDLE_WORD_RST = 32'h7A89_C197;

    typedef enum logic [2:0] {
        KIND_SYNC = 3'd0,
        KIND_IDLE = 3'd1,
        KIND_ADDR = 3'd2,
        KIND_MSG  = 3'd3,
        KIND_NONE = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_NO_START = 2'd2
    } status_t;

    typedef struct packed {
        logic                 action;
        logic [20:0]          address;
        logic [1:0]           function_bits;
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] codeword;
        kind_t       word_kind;
        status_t     status;
        logic        end_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LEAD,
        S_PACK,
        S_AFTER,
        S_BCH,
        S_SYNC,
        S_WORD,
        S_FILL,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        RET_LEAD,
        RET_PACK,
        RET_FILL,
        RET_DONE
    } ret_t;

    typedef struct packed {
        logic    latch_item;
        logic    start_msg;
        logic    clear_active;
        logic    emit_err;
        status_t err_code;
        logic    bch_start;
        logic    bch_msg;
        logic    frame_idle;
        logic    emit_sync;
        logic    emit_word;
        logic    load_char;
        logic    load_eot;
        logic    pack_bit;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic addr_zero;
        logic last;
        logic active;
        logic char_ok;
        logic fp_lt_start;
        logic fp_lt_total;
        logic sync_due;
        logic fill_full;
        logic char_done;
        logic bch_done;
        logic can_emit;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

@@ src/pce_bch.sv @@
// Iterative BCH(31,21) encoder with even parity, three remainder steps per cycle.
// Depends on pce_pkg.
module pce_bch
    import pce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] data,
    output logic        done,
    output logic [31:0] word
);

    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [31:0]          data_reg;
    logic [BCH_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [31:0]          base;

    always_comb
    begin
        rem_next = rem_reg;
        for (int i = 0; i < BCH_STEP; i++)
        begin
            if (rem_next[31])
            begin
                rem_next = rem_next ^ BCH_GEN;
            end
            rem_next = rem_next << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == BCH_CNT_W'(BCH_ITER - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= data & DATA_MASK;
            data_reg <= data & DATA_MASK;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign base = data_reg | {21'b0, rem_reg[31:21]};
    assign word = {base[31:1], base[0] | (^base)};
    assign done = done_reg;

endmodule

@@ src/pce_dp.sv @@
// Datapath: configuration registers, message state, payload packing and result buffering.
// Depends on pce_pkg and pce_bch; driven by pce_ctrl through cmd_t and stat_t.
module pce_dp
    import pce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  in_item_t              item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result
);

    logic [31:0]             sync_word_reg;
    logic [31:0]             idle_word_reg;
    logic                    invert_reg;
    logic [CHAR_BITS-1:0]    max_chars_reg;
    logic [CHAR_BITS-1:0]    limit;

    in_item_t                item_reg;
    logic [FP_W-1:0]         fp_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [CHAR_BITS-1:0]    chars_reg;
    logic                    active_reg;
    logic [CHAR_BITS-1:0]    shift_reg;
    logic [BITCNT_W-1:0]     bitcnt_reg;
    logic                    src_bch_reg;
    kind_t                   frame_kind_reg;
    logic [RES_W-1:0]        res_cnt_reg;
    logic                    pend_valid_reg;
    out_item_t               pend_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;

    logic                    bch_done;
    logic [31:0]             bch_word;
    logic [31:0]             bch_data;
    logic [31:0]             frame_word;
    logic                    emit;
    logic                    room;
    logic                    out_free;
    logic                    push_pend;
    logic                    push_last;
    out_item_t               new_item;

    localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_TOP = {1'b1, {(PAYLOAD_BITS - 1){1'b0}}};

    assign limit      = (max_chars_reg > CHAR_LIMIT) ? CHAR_LIMIT : max_chars_reg;
    assign bch_data   = cmd.bch_msg ? {1'b1, payload_reg, 11'b0}
                                    : {1'b0, item_reg.address[20:3], item_reg.function_bits, 11'b0};
    assign frame_word = src_bch_reg ? bch_word : idle_word_reg;
    assign emit       = cmd.emit_err | cmd.emit_sync | cmd.emit_word;
    assign room       = res_cnt_reg < RES_W'(MAX_RESULTS);
    assign out_free   = !out_valid_reg || result_ready;
    assign push_pend  = emit && room && pend_valid_reg;
    assign push_last  = cmd.finish && pend_valid_reg;

    pce_bch u_bch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.bch_start),
        .data  (bch_data),
        .done  (bch_done),
        .word  (bch_word)
    );

    always_comb
    begin
        new_item = '{codeword: '0, word_kind: KIND_NONE, status: cmd.err_code, end_of_run: 1'b0};
        if (cmd.emit_sync)
        begin
            new_item = '{codeword: sync_word_reg, word_kind: KIND_SYNC, status: ST_OK,
                         end_of_run: 1'b0};
        end
        else if (cmd.emit_word)
        begin
            new_item = '{codeword: frame_word ^ {32{invert_reg}}, word_kind: frame_kind_reg,
                         status: ST_OK, end_of_run: 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SYNC_WORD_RST;
            idle_word_reg <= IDLE_WORD_RST;
            invert_reg    <= 1'b1;
            max_chars_reg <= CHAR_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SYNC_WORD:    sync_word_reg <= cfg_wdata[31:0];
                REG_IDLE_WORD:    idle_word_reg <= cfg_wdata[31:0];
                REG_INVERT_BATCH: invert_reg    <= cfg_wdata[0];
                REG_MAX_CHARS:    max_chars_reg <= cfg_wdata[CHAR_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg      <= '0;
            payload_reg <= '0;
            fill_reg    <= '0;
            chars_reg   <= '0;
            active_reg  <= 1'b0;
            bitcnt_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.latch_item)
            begin
                res_cnt_reg <= '0;
            end
            else if (emit && room)
            begin
                res_cnt_reg <= res_cnt_reg + 1'b1;
            end

            if (cmd.start_msg)
            begin
                fp_reg      <= '0;
                payload_reg <= '0;
                fill_reg    <= '0;
                chars_reg   <= '0;
                active_reg  <= 1'b1;
            end
            else
            begin
                if (cmd.clear_active)
                begin
                    active_reg <= 1'b0;
                end
                if (cmd.emit_word)
                begin
                    fp_reg <= fp_reg + 1'b1;
                end
                if (cmd.bch_start && cmd.bch_msg)
                begin
                    payload_reg <= '0;
                    fill_reg    <= '0;
                end
                else if (cmd.pack_bit)
                begin
                    if (shift_reg[0])
                    begin
                        payload_reg <= payload_reg | (PAYLOAD_TOP >> fill_reg);
                    end
                    fill_reg <= fill_reg + 1'b1;
                end
                if (cmd.load_char)
                begin
                    chars_reg <= chars_reg + 1'b1;
                end
            end

            if (cmd.load_char || cmd.load_eot)
            begin
                bitcnt_reg <= '0;
            end
            else if (cmd.pack_bit)
            begin
                bitcnt_reg <= bitcnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= item;
        end
        if (cmd.load_char)
        begin
            shift_reg <= item_reg.character;
        end
        else if (cmd.load_eot)
        begin
            shift_reg <= EOT_CHAR;
        end
        else if (cmd.pack_bit)
        begin
            shift_reg <= shift_reg >> 1;
        end
        if (cmd.frame_idle)
        begin
            src_bch_reg    <= 1'b0;
            frame_kind_reg <= KIND_IDLE;
        end
        else if (cmd.bch_start)
        begin
            src_bch_reg    <= 1'b1;
            frame_kind_reg <= cmd.bch_msg ? KIND_MSG : KIND_ADDR;
        end
        if (emit && room)
        begin
            pend_reg <= new_item;
        end
        if (push_last)
        begin
            out_reg <= '{codeword: pend_reg.codeword, word_kind: pend_reg.word_kind,
                         status: pend_reg.status, end_of_run: 1'b1};
        end
        else if (push_pend)
        begin
            out_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (emit && room)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push_last)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_pend || push_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.action      = item_reg.action;
    assign stat.addr_zero   = (item_reg.address == '0);
    assign stat.last        = item_reg.last;
    assign stat.active      = active_reg;
    assign stat.char_ok     = chars_reg < limit;
    assign stat.fp_lt_start = fp_reg < FP_W'({item_reg.address[2:0], 1'b0});
    assign stat.fp_lt_total = fp_reg < FP_W'(TOTAL_FRAMES);
    assign stat.sync_due    = (fp_reg[FRAME_IDX_W-1:0] == '0);
    assign stat.fill_full   = (fill_reg == FILL_W'(PAYLOAD_BITS));
    assign stat.char_done   = (bitcnt_reg == BITCNT_W'(CHAR_BITS));
    assign stat.bch_done    = bch_done;
    assign stat.can_emit    = !pend_valid_reg || out_free || !room;
    assign stat.pend_valid  = pend_valid_reg;
    assign stat.out_free    = out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ src/pce_ctrl.sv @@
// Controller state machine that sequences frames, packing and BCH encoding.
// Depends on pce_pkg; drives pce_dp through cmd_t and reads stat_t.
module pce_ctrl
    import pce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t ret_state;
    ret_t        ret_reg;
    ret_t        ret_next;
    logic        eot_reg;
    logic        eot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_DONE;
            eot_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            eot_reg   <= eot_next;
        end
    end

    always_comb
    begin
        unique case (ret_reg)
            RET_LEAD: ret_state = S_LEAD;
            RET_PACK: ret_state = S_PACK;
            RET_FILL: ret_state = S_FILL;
            RET_DONE: ret_state = S_FINISH;
            default:  ret_state = S_FINISH;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        eot_next   = eot_reg;
        cmd        = '0;
        cmd.err_code = ST_OK;
        item_ready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                priority if (!stat.action && stat.addr_zero)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.emit_err     = 1'b1;
                        cmd.err_code     = ST_BAD_ADDR;
                        cmd.clear_active = 1'b1;
                        state_next       = S_FINISH;
                    end
                end
                else if (!stat.action)
                begin
                    cmd.start_msg = 1'b1;
                    state_next    = S_LEAD;
                end
                else if (!stat.active)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.emit_err = 1'b1;
                        cmd.err_code = ST_NO_START;
                        state_next   = S_FINISH;
                    end
                end
                else if (stat.char_ok)
                begin
                    cmd.load_char = 1'b1;
                    eot_next      = 1'b0;
                    state_next    = S_PACK;
                end
                else if (stat.last)
                begin
                    cmd.load_eot = 1'b1;
                    eot_next     = 1'b1;
                    state_next   = S_PACK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_LEAD:
            begin
                if (stat.fp_lt_start)
                begin
                    cmd.frame_idle = 1'b1;
                    ret_next       = RET_LEAD;
                    state_next     = S_SYNC;
                end
                else
                begin
                    cmd.bch_start = 1'b1;
                    ret_next      = RET_DONE;
                    state_next    = S_BCH;
                end
            end

            S_PACK:
            begin
                priority if (stat.fill_full)
                begin
                    cmd.bch_start = 1'b1;
                    cmd.bch_msg   = 1'b1;
                    ret_next      = RET_PACK;
                    state_next    = S_BCH;
                end
                else if (!stat.char_done)
                begin
                    cmd.pack_bit = 1'b1;
                end
                else
                begin
                    state_next = S_AFTER;
                end
            end

            S_AFTER:
            begin
                priority if (eot_reg)
                begin
                    cmd.bch_start = 1'b1;
                    cmd.bch_msg   = 1'b1;
                    ret_next      = RET_FILL;
                    state_next    = S_BCH;
                end
                else if (stat.last)
                begin
                    cmd.load_eot = 1'b1;
                    eot_next     = 1'b1;
                    state_next   = S_PACK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_BCH:
            begin
                if (stat.bch_done)
                begin
                    state_next = S_SYNC;
                end
            end

            S_SYNC:
            begin
                priority if (!stat.fp_lt_total)
                begin
                    state_next = ret_state;
                end
                else if (stat.sync_due)
                begin
                    if (stat.can_emit)
                    begin
                        cmd.emit_sync = 1'b1;
                        state_next    = S_WORD;
                    end
                end
                else
                begin
                    state_next = S_WORD;
                end
            end

            S_WORD:
            begin
                if (stat.can_emit)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = ret_state;
                end
            end

            S_FILL:
            begin
                if (stat.fp_lt_total)
                begin
                    cmd.frame_idle = 1'b1;
                    ret_next       = RET_FILL;
                    state_next     = S_SYNC;
                end
                else
                begin
                    cmd.clear_active = 1'b1;
                    state_next       = S_FINISH;
                end
            end

            S_FINISH:
            begin
                priority if (!stat.pend_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/pager_codeword_encoder_unit.sv @@
// Top level of the pager codeword encoder: controller, datapath and configuration port.
// Depends on pce_pkg, pce_ctrl and pce_dp.
//
// Requests arrive on item_valid/item_ready with an in_item_t payload. A start request
// checks the address and emits sync, leading idle frames and the address codeword; a
// character request packs seven bits into message payloads and, when it is the last
// one, appends EOT, flushes the payload and idle-fills the remaining frames.
// Results leave on result_valid/result_ready as out_item_t; end_of_run marks the final
// result of a request, and a request may produce no result at all.
// One request is handled at a time; item_ready is high only while the controller idles.
// Each frame passes through the sync and word states of the frame loop, and every BCH
// codeword is formed by the encoder unit in passes of three remainder steps.
// The newest result is held back one place so that end_of_run can be set on it; a
// stalled receiver holds the output register and the controller simply waits.
// Reset restores the register defaults and clears all message state.
// Configuration is written by cfg_wr_en/cfg_index/cfg_wdata while the block is idle:
// the user must keep to that, as the block itself does not enforce it.
module pager_codeword_encoder_unit
    import pce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    pce_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pce_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for pager_codeword_encoder_unit: directed and random paging requests
// over several register settings, with random handshake stalls and a bit-exact codeword predictor.
// Depends only on pce_pkg and the encoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pce_pkg::*;

    localparam logic ACT_START     = 1'b0;
    localparam logic ACT_CHAR      = 1'b1;
    localparam int   CYCLE_LIMIT   = 1_500_000;
    localparam int   SETTLE_CYCLES = 200;
    localparam int   LONG_HOLD     = 600;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    in_item_t              item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

    // Register copies and message state of the predictor.
    logic [31:0] cfg_sync   = SYNC_WORD_RST;
    logic [31:0] cfg_idle   = IDLE_WORD_RST;
    logic        cfg_invert = 1'b1;
    logic [6:0]  cfg_max    = CHAR_LIMIT;
    logic [5:0]  pg_frame   = '0;
    logic [19:0] pg_payload = '0;
    logic [4:0]  pg_fill    = '0;
    logic [6:0]  pg_chars   = '0;
    logic        pg_open    = 1'b0;

    in_item_t  pending_requests[$];
    out_item_t expected_words[$];

    int step_n          = 0;
    int n_offered       = 0;
    int n_taken         = 0;
    int words_checked   = 0;
    int mismatches      = 0;
    int dropped_frames  = 0;
    int messages_queued = 0;
    int settings_used   = 1;
    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    int tx_gap          = 0;
    int rx_gap          = 0;
    int rx_hold_left    = 0;
    logic rx_hold_req   = 1'b0;
    logic rx_hold_done  = 1'b0;

    pager_codeword_encoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [6:0] char_cap();
        return (cfg_max > CHAR_LIMIT) ? CHAR_LIMIT : cfg_max;
    endfunction

    function automatic logic [31:0] bch_codeword(input logic [31:0] data);
        logic [31:0] rem;
        logic [31:0] word;
        rem  = data & DATA_MASK;
        word = rem;
        for (int i = 0; i < 21; i++)
        begin
            if (rem[31])
                rem = rem ^ BCH_GEN;
            rem = rem << 1;
        end
        word = word | (rem >> 21);
        if (^word)
            word[0] = 1'b1;
        return word;
    endfunction

    task automatic emit_word(input logic [31:0] w, input kind_t k, input status_t s);
        out_item_t o;
        if (step_n < MAX_RESULTS)
        begin
            o.codeword   = w;
            o.word_kind  = k;
            o.status     = s;
            o.end_of_run = 1'b0;
            expected_words.push_back(o);
            step_n++;
        end
    endtask

    task automatic place_frame(input logic [31:0] w, input kind_t k);
        if (pg_frame >= TOTAL_FRAMES)
            dropped_frames++;
        else
        begin
            if (pg_frame % FRAMES_PER_BATCH == 0)
                emit_word(cfg_sync, KIND_SYNC, ST_OK);
            emit_word(cfg_invert ? ~w : w, k, ST_OK);
            pg_frame++;
        end
    endtask

    task automatic flush_payload();
        place_frame(bch_codeword({1'b1, pg_payload, 11'b0}), KIND_MSG);
        pg_payload = '0;
        pg_fill    = '0;
    endtask

    task automatic pack_char(input logic [6:0] ch);
        for (int i = 0; i < 7; i++)
        begin
            if (ch[i])
                pg_payload[19 - pg_fill] = 1'b1;
            pg_fill++;
            if (pg_fill >= PAYLOAD_BITS)
                flush_payload();
        end
    endtask

    task automatic encode_request(input in_item_t req);
        logic [5:0] lead;
        step_n = 0;
        if (req.action == ACT_START)
        begin
            if (req.address == '0)
            begin
                pg_open = 1'b0;
                emit_word('0, KIND_NONE, ST_BAD_ADDR);
            end
            else
            begin
                pg_frame   = '0;
                pg_payload = '0;
                pg_fill    = '0;
                pg_chars   = '0;
                pg_open    = 1'b1;
                lead       = {2'b00, req.address[2:0], 1'b0};
                while (pg_frame < lead)
                    place_frame(cfg_idle, KIND_IDLE);
                place_frame(bch_codeword({1'b0, req.address[20:3], req.function_bits, 11'b0}),
                            KIND_ADDR);
            end
        end
        else if (!pg_open)
            emit_word('0, KIND_NONE, ST_NO_START);
        else
        begin
            if (pg_chars < char_cap())
            begin
                pack_char(req.character);
                pg_chars++;
            end
            if (req.last)
            begin
                pack_char(EOT_CHAR);
                flush_payload();
                while (pg_frame < TOTAL_FRAMES)
                    place_frame(cfg_idle, KIND_IDLE);
                pg_open = 1'b0;
            end
        end
        if (step_n > 0)
            expected_words[expected_words.size() - 1].end_of_run = 1'b1;
    endtask

    task automatic report_mismatch(input string why, input out_item_t want, input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH (%s) at word %0d: expected %h kind %0d status %0d end %b,",
                     why, words_checked, want.codeword, want.word_kind, want.status,
                     want.end_of_run, " got %h kind %0d status %0d end %b",
                     got.codeword, got.word_kind, got.status, got.end_of_run);
    endtask

    // Requests are predicted when accepted; results are checked in arrival order.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                encode_request(item);
                n_taken <= n_taken + 1;
            end
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected", '0, result);
                else
                begin
                    want = expected_words.pop_front();
                    if (result.codeword !== want.codeword || result.word_kind !== want.word_kind ||
                        result.status !== want.status || result.end_of_run !== want.end_of_run)
                        report_mismatch("field", want, result);
                end
                words_checked++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (item_valid && n_taken != n_offered)
            ;
        else if (tx_gap > 0)
        begin
            tx_gap     <= tx_gap - 1;
            item_valid <= 1'b0;
        end
        else if (pending_requests.size() != 0 && tx_idle_pct != 0 &&
                 $urandom_range(0, 99) < tx_idle_pct)
        begin
            tx_gap     <= $urandom_range(0, 13);
            item_valid <= 1'b0;
        end
        else if (pending_requests.size() != 0)
        begin
            item       <= pending_requests.pop_front();
            item_valid <= 1'b1;
            n_offered  <= n_offered + 1;
        end
        else
            item_valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (rx_hold_req && !rx_hold_done)
        begin
            rx_hold_left <= LONG_HOLD;
            rx_hold_done <= 1'b1;
            result_ready <= 1'b0;
        end
        else if (rx_hold_left > 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap       <= rx_gap - 1;
            result_ready <= 1'b0;
        end
        else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
        begin
            rx_gap       <= $urandom_range(0, 13);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    initial
    begin
        for (int wd = 0; wd < CYCLE_LIMIT; wd++)
            @(posedge clk);
        $display("Timeout after %0d cycles with %0d words outstanding.", CYCLE_LIMIT,
                 expected_words.size());
        $display("tb_top: errors");
        $finish;
    end

    task automatic push_request(input logic act, input logic [20:0] addr, input logic [1:0] fb,
                                input logic [6:0] ch, input logic lst);
        in_item_t r;
        r.action        = act;
        r.address       = addr;
        r.function_bits = fb;
        r.character     = ch;
        r.last          = lst;
        pending_requests.push_back(r);
    endtask

    function automatic logic [20:0] pick_address();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 21'h1FFFFF;
        if (pick < 10)
            return 21'h000001;
        return 21'($urandom_range(1, 21'h1FFFFF));
    endfunction

    task automatic queue_message(input int len, inout int counted);
        push_request(ACT_START, pick_address(), 2'($urandom_range(0, 3)),
                     7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        counted++;
        for (int k = 1; k <= len; k++)
        begin
            push_request(ACT_CHAR, 21'($urandom_range(0, 21'h1FFFFF)), 2'($urandom_range(0, 3)),
                         7'($urandom_range(0, 127)), k == len);
            counted++;
        end
        messages_queued++;
    endtask

    task automatic random_phase(input int target);
        int counted;
        int pick;
        int len;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(0, 99);
            if (len < 55)
                len = $urandom_range(1, 8);
            else if (len < 93)
                len = $urandom_range(9, 25);
            else
                len = $urandom_range(60, 90);
            if (len > target - counted - 1)
                len = (target - counted > 1) ? target - counted - 1 : 1;
            if (pick < 80)
                queue_message(len, counted);
            else if (pick < 86)
            begin
                push_request(ACT_CHAR, 21'($urandom_range(0, 21'h1FFFFF)),
                             2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                             1'($urandom_range(0, 1)));
                counted++;
            end
            else if (pick < 92)
            begin
                push_request(ACT_START, '0, 2'($urandom_range(0, 3)),
                             7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                counted++;
            end
            else
            begin
                // An open message, cut off by an invalid address or left for the next request.
                push_request(ACT_START, pick_address(), 2'($urandom_range(0, 3)),
                             7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                counted++;
                len = $urandom_range(0, 6);
                for (int k = 1; k <= len; k++)
                begin
                    push_request(ACT_CHAR, 21'($urandom_range(0, 21'h1FFFFF)),
                                 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), 1'b0);
                    counted++;
                end
                if (pick < 96)
                begin
                    push_request(ACT_START, '0, 2'($urandom_range(0, 3)),
                                 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                    counted++;
                end
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_requests.size() != 0 || n_taken != n_offered ||
               expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            REG_SYNC_WORD:    cfg_sync   = val;
            REG_IDLE_WORD:    cfg_idle   = val;
            REG_INVERT_BATCH: cfg_invert = val[0];
            REG_MAX_CHARS:    cfg_max    = val[6:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] sync_val, input logic [31:0] idle_val,
                                  input logic inv, input logic [6:0] max_val);
        write_reg(REG_SYNC_WORD, sync_val);
        write_reg(REG_IDLE_WORD, idle_val);
        write_reg(REG_INVERT_BATCH, {31'b0, inv});
        write_reg(REG_MAX_CHARS, {25'b0, max_val});
        settings_used++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Error cases first, then a 19-character message from the highest address, whose
        // EOT exactly fills a payload and so forces a flush of an empty one, then a stray character.
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        push_request(ACT_CHAR, 21'h0AAAAA, 2'd1, 7'h55, 1'b0);
        push_request(ACT_START, '0, 2'd2, 7'h2A, 1'b1);
        push_request(ACT_START, 21'h1FFFFF, 2'd3, 7'h00, 1'b0);
        for (int k = 0; k < 18; k++)
            push_request(ACT_CHAR, 21'($urandom_range(0, 21'h1FFFFF)), 2'($urandom_range(0, 3)),
                         (k % 2) ? 7'h00 : 7'h7F, 1'b0);
        push_request(ACT_CHAR, 21'h1FFFFF, 2'd0, 7'h7F, 1'b1);
        push_request(ACT_CHAR, 21'h000000, 2'd3, 7'h00, 1'b0);
        messages_queued++;
        wait_quiet();

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        apply_settings($urandom, $urandom, 1'b0, 7'd80);
        random_phase(32);
        wait_quiet();
        random_phase(33);
        wait_quiet();

        tx_idle_pct = 35;
        rx_idle_pct = 10;
        apply_settings(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 7'd1);
        random_phase(65);
        wait_quiet();

        tx_idle_pct = 10;
        rx_idle_pct = 35;
        apply_settings(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 7'd127);
        rx_hold_req = 1'b1;
        random_phase(65);
        wait_quiet();

        tx_idle_pct = 25;
        rx_idle_pct = 25;
        apply_settings($urandom, $urandom, 1'b1, 7'($urandom_range(1, 127)));
        random_phase(65);
        wait_quiet();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(SYNC_WORD_RST, IDLE_WORD_RST, 1'b1, CHAR_LIMIT);
        random_phase(30);
        wait_quiet();

        $display("Run covered %0d requests in %0d messages over %0d register settings.",
                 n_taken, messages_queued, settings_used);
        $display("Checked %0d codewords; %0d frames fell past the last batch; %0d mismatches.",
                 words_checked, dropped_frames, mismatches);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
